/* rtl/ble_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Shared widths, codes and the converter threshold table of the battery
// level estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

  localparam int LVL_W      = 5;
  localparam int ADC_W      = 10;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_INIT   = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_CHARGE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_INTERVAL   = 2'd2;

  localparam logic [TICK_W-1:0] NORMAL_INTERVAL_RST = 16'd1800;
  localparam logic [TICK_W-1:0] FAST_INTERVAL_RST   = 16'd600;
  localparam logic [TICK_W-1:0] TICK_MAX            = 16'hFFFF;

  localparam int THRESH_COUNT = 21;

  // Rising converter thresholds, one per level boundary
  localparam logic [ADC_W-1:0] THRESH [THRESH_COUNT] = '{
    10'd345, 10'd351, 10'd356, 10'd362, 10'd367, 10'd373, 10'd378,
    10'd384, 10'd389, 10'd395, 10'd401, 10'd406, 10'd412, 10'd417,
    10'd423, 10'd428, 10'd434, 10'd439, 10'd445, 10'd450, 10'd456
  };

endpackage

/* rtl/ble_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_in_if
// Input channel: valid/ready handshake with one estimator item as payload.
// ----------------------------------------------------------------------------
interface ble_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [ble_pkg::ADC_W-1:0]    adc_value;
  logic                         charger_on;
  logic                         charging_active;

  modport source (output valid, action, adc_value, charger_on, charging_active,
                  input ready);
  modport sink   (input valid, action, adc_value, charger_on, charging_active,
                  output ready);
endinterface

/* rtl/ble_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_out_if
// Result channel: valid/ready handshake with one level report as payload.
// ----------------------------------------------------------------------------
interface ble_out_if;
  logic                         valid;
  logic                         ready;
  logic [ble_pkg::LVL_W-1:0]    battery_level;
  logic                         level_changed;
  logic [ble_pkg::LVL_W-1:0]    quick_level;
  logic [ble_pkg::LVL_W-1:0]    smoothed_level;

  modport source (output valid, battery_level, level_changed, quick_level,
                  smoothed_level, input ready);
  modport sink   (input valid, battery_level, level_changed, quick_level,
                  smoothed_level, output ready);
endinterface

/* rtl/battery_level_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_estimator
// Displayed battery level from converter readings, with two averaging
// windows and charge stepping.
// ----------------------------------------------------------------------------
// Usage
//   item   : sink channel. Each transaction is a sample, a one-second tick or
//            an init from a converter reading. Every transaction yields
//            exactly one result transaction, in order.
//   result : source channel carrying the displayed level, the level-changed
//            flag, the quick level and the smoothed level after the item.
//   cfg_*  : write port for fast_charge (index 0), normal_interval (1) and
//            fast_interval (2). Write only while no item is in flight.
// Timing
//   Three register stages: quantise and sample window, then sample mean and
//   quick window, then quick mean and displayed level into the result
//   register; one item is accepted per cycle while the result is not stalled.
//   Each window mean is a constant-reciprocal multiply in a stage of its own,
//   which sets the stage split.
// Reset
//   All windows, averages, counters and the pipeline clear; intervals load
//   1800 and 600 ticks, fast_charge clears.
// Stall
//   While a result waits on result.ready the whole pipeline holds and
//   item.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module battery_level_estimator #(
  parameter int SAMPLE_DEPTH = 8,
  parameter int QUICK_DEPTH  = 8,
  parameter int FULL_LEVEL   = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  ble_in_if.sink                          item,
  ble_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [ble_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ble_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW = ble_pkg::LVL_W;
  localparam int TW = ble_pkg::TICK_W;

  // Window sums hold FULL_LEVEL * depth at most
  localparam int SS_W  = $clog2(FULL_LEVEL * SAMPLE_DEPTH + 1);
  localparam int QS_W  = $clog2(FULL_LEVEL * QUICK_DEPTH + 1);
  // Round-up reciprocal: exact floor division for any SS_W-bit sum
  localparam int SS_SH = SS_W + $clog2(SAMPLE_DEPTH);
  localparam int QS_SH = QS_W + $clog2(QUICK_DEPTH);
  localparam int SS_M  = ((1 << SS_SH) + SAMPLE_DEPTH - 1) / SAMPLE_DEPTH;
  localparam int QS_M  = ((1 << QS_SH) + QUICK_DEPTH - 1) / QUICK_DEPTH;
  localparam int SP_W  = SS_W + SS_SH + 1;
  localparam int QP_W  = QS_W + QS_SH + 1;
  localparam int T_EFF = (FULL_LEVEL < ble_pkg::THRESH_COUNT) ? FULL_LEVEL
                                                              : ble_pkg::THRESH_COUNT;
  localparam logic [LW-1:0] FULL = LW'(FULL_LEVEL);

  // Configuration
  logic          fast_charge;
  logic [TW-1:0] normal_interval;
  logic [TW-1:0] fast_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_charge     <= 1'b0;
      normal_interval <= ble_pkg::NORMAL_INTERVAL_RST;
      fast_interval   <= ble_pkg::FAST_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ble_pkg::CFG_FAST_CHARGE:     fast_charge     <= cfg_data[0];
        ble_pkg::CFG_NORMAL_INTERVAL: normal_interval <= cfg_data[TW-1:0];
        ble_pkg::CFG_FAST_INTERVAL:   fast_interval   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves whenever the result register is free
  logic advance;
  logic accept;
  assign advance    = !result.valid || result.ready;
  assign item.ready = advance;
  assign accept     = item.valid && advance;

  // --------------------------------------------------------------------------
  // Stage 1: quantise the reading, push into the sample window
  // --------------------------------------------------------------------------
  logic [ble_pkg::THRESH_COUNT-1:0] above;
  logic [LW-1:0]                    above_cnt;
  logic [LW-1:0]                    q_lv;
  ble_pkg::action_t                 in_act;

  always_comb begin
    for (int i = 0; i < ble_pkg::THRESH_COUNT; i++) begin
      above[i] = (i < FULL_LEVEL) && (item.adc_value >= ble_pkg::THRESH[i]);
    end
    above_cnt = LW'($countones(above));
    // Past every threshold that counts: top level
    q_lv      = (above_cnt == LW'(T_EFF)) ? FULL : above_cnt;
    in_act    = ble_pkg::action_t'(item.action);
  end

  logic [LW-1:0]   sample_window [SAMPLE_DEPTH];
  logic [SS_W-1:0] sample_sum;
  logic [SS_W-1:0] sample_sum_next;

  always_comb begin
    sample_sum_next = sample_sum;
    case (in_act)
      ble_pkg::ACT_SAMPLE: sample_sum_next = sample_sum - SS_W'(sample_window[0])
                                             + SS_W'(q_lv);
      ble_pkg::ACT_INIT:   sample_sum_next = SS_W'(SS_W'(q_lv) * SS_W'(SAMPLE_DEPTH));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum <= '0;
      for (int i = 0; i < SAMPLE_DEPTH; i++) sample_window[i] <= '0;
    end else if (accept) begin
      sample_sum <= sample_sum_next;
      if (in_act == ble_pkg::ACT_SAMPLE) begin
        // Advance the window: drop the oldest, append the new level
        for (int i = 0; i < SAMPLE_DEPTH - 1; i++) sample_window[i] <= sample_window[i + 1];
        sample_window[SAMPLE_DEPTH-1] <= q_lv;
      end else if (in_act == ble_pkg::ACT_INIT) begin
        for (int i = 0; i < SAMPLE_DEPTH; i++) sample_window[i] <= q_lv;
      end
    end
  end

  logic             p1_valid;
  logic [1:0]       p1_action;
  logic [LW-1:0]    p1_lv;
  logic             p1_charger;
  logic             p1_charging;
  logic [SS_W-1:0]  p1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_action   <= item.action;
      p1_lv       <= q_lv;
      p1_charger  <= item.charger_on;
      p1_charging <= item.charging_active;
      p1_sum      <= sample_sum_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sample mean, lowest average, quick level, quick window
  // --------------------------------------------------------------------------
  ble_pkg::action_t p1_act;
  logic [SP_W-1:0]  s_prod;
  logic [LW-1:0]    s_avg;
  logic [LW-1:0]    lowest_average;
  logic [LW-1:0]    lowest_next;
  logic [LW-1:0]    quick_average;
  logic [LW-1:0]    quick_next;
  logic [LW-1:0]    quick_window [QUICK_DEPTH];
  logic [QS_W-1:0]  quick_sum;
  logic [QS_W-1:0]  quick_sum_next;
  logic [LW:0]      pair_sum;
  logic             p1_go;

  assign p1_go = p1_valid && advance;

  always_comb begin
    p1_act         = ble_pkg::action_t'(p1_action);
    s_prod         = SP_W'(p1_sum) * SP_W'(SS_M);
    s_avg          = s_prod[SS_SH +: LW];
    lowest_next    = lowest_average;
    quick_next     = quick_average;
    quick_sum_next = quick_sum;
    pair_sum       = '0;
    case (p1_act)
      ble_pkg::ACT_SAMPLE: begin
        lowest_next    = (s_avg < lowest_average) ? s_avg : lowest_average;
        pair_sum       = {1'b0, lowest_next} + {1'b0, s_avg};
        quick_next     = pair_sum[LW:1];
        quick_sum_next = quick_sum - QS_W'(quick_window[0]) + QS_W'(quick_next);
      end
      ble_pkg::ACT_INIT: begin
        lowest_next    = p1_lv;
        quick_next     = p1_lv;
        quick_sum_next = QS_W'(QS_W'(p1_lv) * QS_W'(QUICK_DEPTH));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_average <= '0;
      quick_average  <= '0;
      quick_sum      <= '0;
      for (int i = 0; i < QUICK_DEPTH; i++) quick_window[i] <= '0;
    end else if (p1_go) begin
      lowest_average <= lowest_next;
      quick_average  <= quick_next;
      quick_sum      <= quick_sum_next;
      if (p1_act == ble_pkg::ACT_SAMPLE) begin
        for (int i = 0; i < QUICK_DEPTH - 1; i++) quick_window[i] <= quick_window[i + 1];
        quick_window[QUICK_DEPTH-1] <= quick_next;
      end else if (p1_act == ble_pkg::ACT_INIT) begin
        for (int i = 0; i < QUICK_DEPTH; i++) quick_window[i] <= p1_lv;
      end
    end
  end

  logic             p2_valid;
  logic [1:0]       p2_action;
  logic [LW-1:0]    p2_lv;
  logic             p2_charger;
  logic             p2_charging;
  logic [LW-1:0]    p2_quick;
  logic [QS_W-1:0]  p2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (advance) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_action   <= p1_action;
      p2_lv       <= p1_lv;
      p2_charger  <= p1_charger;
      p2_charging <= p1_charging;
      p2_quick    <= quick_next;
      p2_sum      <= quick_sum_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: smoothed level, charge stepping, displayed level
  // --------------------------------------------------------------------------
  ble_pkg::action_t p2_act;
  logic [QP_W-1:0]  q_prod;
  logic [LW-1:0]    q_avg;
  logic [LW-1:0]    smoothed_average;
  logic [LW-1:0]    smoothed_next;
  logic [LW-1:0]    charge_step;
  logic [LW-1:0]    charge_step_next;
  logic [TW-1:0]    charge_ticks;
  logic [TW-1:0]    charge_ticks_next;
  logic [LW-1:0]    shown_level;
  logic [LW-1:0]    shown_next;
  logic             changed_next;
  logic [TW-1:0]    limit;
  logic [LW-1:0]    cap;
  logic             p2_go;

  assign p2_go = p2_valid && advance;

  always_comb begin
    p2_act            = ble_pkg::action_t'(p2_action);
    q_prod            = QP_W'(p2_sum) * QP_W'(QS_M);
    q_avg             = q_prod[QS_SH +: LW];
    limit             = fast_charge ? fast_interval : normal_interval;
    smoothed_next     = smoothed_average;
    charge_step_next  = charge_step;
    charge_ticks_next = charge_ticks;
    shown_next        = shown_level;
    changed_next      = 1'b0;
    cap               = '0;
    case (p2_act)
      ble_pkg::ACT_SAMPLE: begin
        smoothed_next = q_avg;
        if (p2_charger) begin
          // Step up once the interval has strictly elapsed
          if (charge_ticks > limit) begin
            charge_ticks_next = '0;
            charge_step_next  = (charge_step >= FULL) ? FULL : charge_step + LW'(1);
          end
          cap          = (q_avg < charge_step_next) ? q_avg : charge_step_next;
          shown_next   = cap;
          changed_next = (shown_level != cap);
        end else if (q_avg < shown_level) begin
          // Discharging: only fall
          shown_next        = q_avg;
          charge_step_next  = q_avg;
          charge_ticks_next = '0;
        end
      end
      ble_pkg::ACT_TICK: begin
        if (p2_charging) begin
          if (charge_ticks != ble_pkg::TICK_MAX) charge_ticks_next = charge_ticks + TW'(1);
        end else if (charge_ticks != '0) begin
          charge_ticks_next = charge_ticks - TW'(1);
        end
      end
      ble_pkg::ACT_INIT: begin
        smoothed_next     = p2_lv;
        charge_step_next  = p2_lv;
        charge_ticks_next = '0;
        shown_next        = p2_lv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_average <= '0;
      charge_step      <= '0;
      charge_ticks     <= '0;
      shown_level      <= '0;
    end else if (p2_go) begin
      smoothed_average <= smoothed_next;
      charge_step      <= charge_step_next;
      charge_ticks     <= charge_ticks_next;
      shown_level      <= shown_next;
    end
  end

  // Result register: load on advance, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.battery_level  <= shown_next;
      result.level_changed  <= changed_next;
      result.quick_level    <= p2_quick;
      result.smoothed_level <= smoothed_next;
    end
  end

endmodule

/* rtl/ble_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks on the battery level estimator, bound to its top level.
// ----------------------------------------------------------------------------
module ble_checker #(
  parameter int FULL_LEVEL = 20
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [ble_pkg::LVL_W-1:0]   battery_level,
  input logic                        level_changed,
  input logic [ble_pkg::LVL_W-1:0]   quick_level,
  input logic [ble_pkg::LVL_W-1:0]   smoothed_level
);

  // Hold a stalled result unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(battery_level)
      && $stable(level_changed) && $stable(quick_level) && $stable(smoothed_level))
    else $error("stalled result changed or dropped");

  // An empty or draining result register never blocks new items
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> item_ready)
    else $error("item channel blocked with result register free");

  // A charging change never shows above the smoothed level
  a_changed_cap: assert property (@(posedge clk) disable iff (rst)
    res_valid && level_changed |-> battery_level <= smoothed_level)
    else $error("changed level above smoothed level");

  // Levels stay within range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> battery_level <= ble_pkg::LVL_W'(FULL_LEVEL)
      && quick_level <= ble_pkg::LVL_W'(FULL_LEVEL)
      && smoothed_level <= ble_pkg::LVL_W'(FULL_LEVEL))
    else $error("level out of range");

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind battery_level_estimator ble_checker #(.FULL_LEVEL(FULL_LEVEL)) u_ble_checker (
  .clk            (clk),
  .rst            (rst),
  .item_ready     (item.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .battery_level  (result.battery_level),
  .level_changed  (result.level_changed),
  .quick_level    (result.quick_level),
  .smoothed_level (result.smoothed_level)
);
